// ===== src/hep_pkg.sv =====
// Shared constants and types for the hull edge pivot select block.
package hep_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int INDEX_BITS_DEF = 12;
    localparam int BAND_BITS      = 48;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_EDGE_START_X = 3'd0,
        REG_EDGE_START_Y = 3'd1,
        REG_EDGE_START_Z = 3'd2,
        REG_EDGE_END_X   = 3'd3,
        REG_EDGE_END_Y   = 3'd4,
        REG_EDGE_END_Z   = 3'd5,
        REG_FLAT_BAND    = 3'd6
    } cfg_reg_t;

    // Run position of a queued candidate, set by the front end
    typedef struct packed {
        logic run_first;
        logic run_last;
    } item_tag_t;

endpackage

// ===== src/hep_front.sv =====
// Front end: accepts candidates, tags run position and forms the offsets from the edge start.
module hep_front #(
    parameter int COORD_BITS = hep_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = hep_pkg::INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_cand_x,
    input  logic signed [COORD_BITS-1:0]  s_cand_y,
    input  logic signed [COORD_BITS-1:0]  s_cand_z,
    input  logic [INDEX_BITS-1:0]         s_cand_index,
    input  logic                          s_run_last,
    input  logic signed [COORD_BITS-1:0]  cfg_start_x,
    input  logic signed [COORD_BITS-1:0]  cfg_start_y,
    input  logic signed [COORD_BITS-1:0]  cfg_start_z,
    input  logic                          q_full,
    output logic                          q_push,
    output hep_pkg::item_tag_t            q_tag,
    output logic [INDEX_BITS-1:0]         q_index,
    output logic signed [COORD_BITS-1:0]  q_cand_x,
    output logic signed [COORD_BITS-1:0]  q_cand_y,
    output logic signed [COORD_BITS-1:0]  q_cand_z,
    output logic signed [COORD_BITS:0]    q_dx,
    output logic signed [COORD_BITS:0]    q_dy,
    output logic signed [COORD_BITS:0]    q_dz
);
    import hep_pkg::*;

    logic run_open_reg;
    logic run_open_next;

    // Take a transfer whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify: the first candidate after a closed run opens a new one
    assign q_tag.run_first = !run_open_reg;
    assign q_tag.run_last  = s_run_last;

    assign q_index  = s_cand_index;
    assign q_cand_x = s_cand_x;
    assign q_cand_y = s_cand_y;
    assign q_cand_z = s_cand_z;

    // Offset of the candidate from the edge start
    assign q_dx = {s_cand_x[COORD_BITS-1], s_cand_x} - {cfg_start_x[COORD_BITS-1], cfg_start_x};
    assign q_dy = {s_cand_y[COORD_BITS-1], s_cand_y} - {cfg_start_y[COORD_BITS-1], cfg_start_y};
    assign q_dz = {s_cand_z[COORD_BITS-1], s_cand_z} - {cfg_start_z[COORD_BITS-1], cfg_start_z};

    always_comb begin
        run_open_next = run_open_reg;
        if (q_push) begin
            run_open_next = !s_run_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg <= 1'b0;
        end else begin
            run_open_reg <= run_open_next;
        end
    end

endmodule

// ===== src/hep_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
module hep_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hep_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             head_valid
);
    import hep_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue fill level lost a write");

endmodule

// ===== src/hep_back.sv =====
// Back end: volume and area arithmetic, best-vertex update and result register.
module hep_back #(
    parameter int COORD_BITS = hep_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = hep_pkg::INDEX_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               head_valid,
    input  hep_pkg::item_tag_t                 head_tag,
    input  logic [INDEX_BITS-1:0]              head_index,
    input  logic signed [COORD_BITS-1:0]       head_cand_x,
    input  logic signed [COORD_BITS-1:0]       head_cand_y,
    input  logic signed [COORD_BITS-1:0]       head_cand_z,
    input  logic signed [COORD_BITS:0]         head_dx,
    input  logic signed [COORD_BITS:0]         head_dy,
    input  logic signed [COORD_BITS:0]         head_dz,
    output logic                               head_pop,
    input  logic signed [COORD_BITS-1:0]       cfg_start_x,
    input  logic signed [COORD_BITS-1:0]       cfg_start_y,
    input  logic signed [COORD_BITS-1:0]       cfg_start_z,
    input  logic signed [COORD_BITS-1:0]       cfg_end_x,
    input  logic signed [COORD_BITS-1:0]       cfg_end_y,
    input  logic signed [COORD_BITS-1:0]       cfg_end_z,
    input  logic [hep_pkg::BAND_BITS-1:0]      cfg_band,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [INDEX_BITS-1:0]              m_pivot_index,
    output logic signed [COORD_BITS-1:0]       m_pivot_x,
    output logic signed [COORD_BITS-1:0]       m_pivot_y,
    output logic signed [COORD_BITS-1:0]       m_pivot_z
);
    import hep_pkg::*;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W;
    localparam int VTERM_W = DIFF_W + CROSS_W;
    localparam int VOL_W   = VTERM_W + 2;
    localparam int SQ_W    = 4 * COORD_BITS + 2;
    localparam int AREA_W  = SQ_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CROSS  = 4'b0010,
        ST_DOT    = 4'b0100,
        ST_DECIDE = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    // Item being worked on
    item_tag_t                   item_tag_reg;
    logic [INDEX_BITS-1:0]       item_index_reg;
    logic signed [COORD_BITS-1:0] item_x_reg, item_y_reg, item_z_reg;

    // Pipeline of the arithmetic
    logic signed [PROD_W-1:0]  pa_reg [6];
    logic signed [PROD_W-1:0]  pb_reg [6];
    logic signed [CROSS_W-1:0] c1_reg [3];
    logic signed [CROSS_W-1:0] c2_reg [3];
    logic signed [VTERM_W-1:0] vterm_reg [3];
    logic [SQ_W-1:0]           sq_reg [3];

    // Best vertex of the open run
    logic signed [COORD_BITS-1:0] best_x_reg, best_y_reg, best_z_reg;
    logic [INDEX_BITS-1:0]        best_id_reg;
    logic [AREA_W-1:0]            best_area_reg;
    logic signed [COORD_BITS-1:0] best_x_next, best_y_next, best_z_next;
    logic [INDEX_BITS-1:0]        best_id_next;
    logic [AREA_W-1:0]            best_area_next;

    // Result register
    logic                         m_valid_reg;
    logic [INDEX_BITS-1:0]        m_index_reg;
    logic signed [COORD_BITS-1:0] m_x_reg, m_y_reg, m_z_reg;

    logic signed [DIFF_W-1:0] ux, uy, uz;
    logic signed [DIFF_W-1:0] vx, vy, vz;
    logic signed [VOL_W-1:0]  vol;
    logic [VOL_W-1:0]         vol_mag;
    logic [AREA_W-1:0]        area;
    logic                     flat;
    logic                     take_point;
    logic                     take_area;
    logic                     decide_fire;

    function automatic logic signed [PROD_W-1:0] mul_dd(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        mul_dd = PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic signed [VTERM_W-1:0] mul_dc(
        input logic signed [DIFF_W-1:0]  a,
        input logic signed [CROSS_W-1:0] b
    );
        mul_dc = VTERM_W'(a) * VTERM_W'(b);
    endfunction

    function automatic logic [SQ_W-1:0] square_c(input logic signed [CROSS_W-1:0] a);
        logic signed [2*CROSS_W-1:0] full_sq;
        full_sq  = (2*CROSS_W)'(a) * (2*CROSS_W)'(a);
        square_c = full_sq[SQ_W-1:0];
    endfunction

    // Edge direction and offset of the current best from the edge start
    assign ux = {cfg_end_x[COORD_BITS-1], cfg_end_x} - {cfg_start_x[COORD_BITS-1], cfg_start_x};
    assign uy = {cfg_end_y[COORD_BITS-1], cfg_end_y} - {cfg_start_y[COORD_BITS-1], cfg_start_y};
    assign uz = {cfg_end_z[COORD_BITS-1], cfg_end_z} - {cfg_start_z[COORD_BITS-1], cfg_start_z};
    assign vx = {best_x_reg[COORD_BITS-1], best_x_reg} - {cfg_start_x[COORD_BITS-1], cfg_start_x};
    assign vy = {best_y_reg[COORD_BITS-1], best_y_reg} - {cfg_start_y[COORD_BITS-1], cfg_start_y};
    assign vz = {best_z_reg[COORD_BITS-1], best_z_reg} - {cfg_start_z[COORD_BITS-1], cfg_start_z};

    assign head_pop = (state_reg == ST_IDLE) && head_valid;

    // Hold in the decide step while a finished pivot cannot be placed
    assign decide_fire = (state_reg == ST_DECIDE)
                         && (!item_tag_reg.run_last || !m_valid_reg || m_ready);

    // Sequence one item through four steps
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (head_valid) state_next = ST_CROSS;
            ST_CROSS:  state_next = ST_DOT;
            ST_DOT:    state_next = ST_DECIDE;
            ST_DECIDE: if (decide_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Step one: latch the item and form the cross-product terms
    always_ff @(posedge aclk) begin
        if (head_pop) begin
            item_tag_reg   <= head_tag;
            item_index_reg <= head_index;
            item_x_reg     <= head_cand_x;
            item_y_reg     <= head_cand_y;
            item_z_reg     <= head_cand_z;
            pa_reg[0] <= mul_dd(vy, head_dz);
            pa_reg[1] <= mul_dd(vz, head_dy);
            pa_reg[2] <= mul_dd(vz, head_dx);
            pa_reg[3] <= mul_dd(vx, head_dz);
            pa_reg[4] <= mul_dd(vx, head_dy);
            pa_reg[5] <= mul_dd(vy, head_dx);
            pb_reg[0] <= mul_dd(uy, head_dz);
            pb_reg[1] <= mul_dd(uz, head_dy);
            pb_reg[2] <= mul_dd(uz, head_dx);
            pb_reg[3] <= mul_dd(ux, head_dz);
            pb_reg[4] <= mul_dd(ux, head_dy);
            pb_reg[5] <= mul_dd(uy, head_dx);
        end
    end

    // Step two: finish both cross products
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CROSS) begin
            for (int i = 0; i < 3; i++) begin
                c1_reg[i] <= pa_reg[2*i] - pa_reg[2*i+1];
                c2_reg[i] <= pb_reg[2*i] - pb_reg[2*i+1];
            end
        end
    end

    // Step three: volume terms and squared area terms
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DOT) begin
            vterm_reg[0] <= mul_dc(ux, c1_reg[0]);
            vterm_reg[1] <= mul_dc(uy, c1_reg[1]);
            vterm_reg[2] <= mul_dc(uz, c1_reg[2]);
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= square_c(c2_reg[i]);
            end
        end
    end

    // Step four: sum, test against the flat band and pick the best
    assign vol = VOL_W'(vterm_reg[0]) + VOL_W'(vterm_reg[1]) + VOL_W'(vterm_reg[2]);
    assign vol_mag = vol[VOL_W-1] ? VOL_W'(-vol) : VOL_W'(vol);
    assign area = AREA_W'(sq_reg[0]) + AREA_W'(sq_reg[1]) + AREA_W'(sq_reg[2]);
    assign flat = (vol == '0) || (BAND_BITS'(vol_mag) < cfg_band);
    assign take_area  = item_tag_reg.run_first || (flat && (area > best_area_reg));
    assign take_point = take_area || (!item_tag_reg.run_first && !flat && vol[VOL_W-1]);

    always_comb begin
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        best_z_next    = best_z_reg;
        best_id_next   = best_id_reg;
        best_area_next = best_area_reg;
        if (take_point) begin
            best_x_next  = item_x_reg;
            best_y_next  = item_y_reg;
            best_z_next  = item_z_reg;
            best_id_next = item_index_reg;
        end
        if (take_area) begin
            best_area_next = area;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_z_reg    <= '0;
            best_id_reg   <= '0;
            best_area_reg <= '0;
        end else if (decide_fire) begin
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            best_z_reg    <= best_z_next;
            best_id_reg   <= best_id_next;
            best_area_reg <= best_area_next;
        end
    end

    // Result register: load on the run's last vertex, drop once transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (decide_fire && item_tag_reg.run_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (decide_fire && item_tag_reg.run_last) begin
            m_index_reg <= best_id_next;
            m_x_reg     <= best_x_next;
            m_y_reg     <= best_y_next;
            m_z_reg     <= best_z_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pivot_index = m_index_reg;
    assign m_pivot_x     = m_x_reg;
    assign m_pivot_y     = m_y_reg;
    assign m_pivot_z     = m_z_reg;

    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |=> state_reg == ST_CROSS ##1 state_reg == ST_DOT
                     ##1 state_reg == ST_DECIDE)
        else $error("item did not walk the arithmetic steps in order");

    a_pivot_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide_fire && item_tag_reg.run_last)
            |=> m_valid_reg && (m_pivot_index == $past(best_id_next)))
        else $error("run closed without its pivot in the result register");

    a_stall_holds_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && !decide_fire)
            |=> $stable(best_id_reg) && $stable(best_area_reg) && state_reg == ST_DECIDE)
        else $error("best vertex changed while the result side stalled");

endmodule

// ===== src/hull_edge_pivot_select_top.sv =====
// Top level of the gift-wrapping pivot selector around one hull edge.
//
// Usage:
//   Write the edge endpoints and the flat band through the cfg_wr_* port while
//   the block is idle (index 0..2 start x/y/z, 3..5 end x/y/z, 6 flat band).
//   Candidates arrive on the s_ channel (valid/ready), grouped into runs; the
//   first candidate of a run seeds the best vertex, s_run_last closes it.
//   For every closed run one pivot leaves on the m_ channel (valid/ready).
// Timing:
//   Each candidate passes through four steps of the arithmetic back end: cross
//   terms, cross products, volume/area terms, decision. The back end handles
//   one candidate at a time because the next volume needs the best vertex
//   chosen by this one, so a new candidate enters only after the last one's decision.
//   With the back end free, m_valid rises once the run's last candidate on s_
//   has passed the queue, the four steps and the result register.
//   A two-entry queue lets the input side keep taking transfers meanwhile.
// Reset and stall:
//   aresetn (synchronous, active low) clears the configuration, the queue,
//   the open run and the result register. If the receiver holds m_ready low,
//   the pivot waits in the result register; a further run end stalls the back
//   end in its decision step, the queue fills and s_ready then drops.
module hull_edge_pivot_select_top #(
    parameter int COORD_BITS = hep_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = hep_pkg::INDEX_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_cand_x,
    input  logic signed [COORD_BITS-1:0]        s_cand_y,
    input  logic signed [COORD_BITS-1:0]        s_cand_z,
    input  logic [INDEX_BITS-1:0]               s_cand_index,
    input  logic                                s_run_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [INDEX_BITS-1:0]               m_pivot_index,
    output logic signed [COORD_BITS-1:0]        m_pivot_x,
    output logic signed [COORD_BITS-1:0]        m_pivot_y,
    output logic signed [COORD_BITS-1:0]        m_pivot_z,
    input  logic                                cfg_wr_en,
    input  logic [hep_pkg::CFG_INDEX_BITS-1:0]  cfg_wr_index,
    input  logic [hep_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);
    import hep_pkg::*;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int ENTRY_W = $bits(item_tag_t) + INDEX_BITS + 3 * COORD_BITS + 3 * DIFF_W;

    // Configuration registers
    logic signed [COORD_BITS-1:0] cfg_sx_reg, cfg_sy_reg, cfg_sz_reg;
    logic signed [COORD_BITS-1:0] cfg_ex_reg, cfg_ey_reg, cfg_ez_reg;
    logic [BAND_BITS-1:0]         cfg_band_reg;

    // Front end to queue
    logic                         q_full;
    logic                         q_push;
    item_tag_t                    q_tag;
    logic [INDEX_BITS-1:0]        q_index;
    logic signed [COORD_BITS-1:0] q_cand_x, q_cand_y, q_cand_z;
    logic signed [DIFF_W-1:0]     q_dx, q_dy, q_dz;
    logic [ENTRY_W-1:0]           q_push_data;

    // Queue to back end
    logic                         h_valid;
    logic                         h_pop;
    logic [ENTRY_W-1:0]           h_data;
    item_tag_t                    h_tag;
    logic [INDEX_BITS-1:0]        h_index;
    logic signed [COORD_BITS-1:0] h_cand_x, h_cand_y, h_cand_z;
    logic signed [DIFF_W-1:0]     h_dx, h_dy, h_dz;

    // Write a configuration register; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_sx_reg   <= '0;
            cfg_sy_reg   <= '0;
            cfg_sz_reg   <= '0;
            cfg_ex_reg   <= '0;
            cfg_ey_reg   <= '0;
            cfg_ez_reg   <= '0;
            cfg_band_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_EDGE_START_X: cfg_sx_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_EDGE_START_Y: cfg_sy_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_EDGE_START_Z: cfg_sz_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_EDGE_END_X:   cfg_ex_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_EDGE_END_Y:   cfg_ey_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_EDGE_END_Z:   cfg_ez_reg   <= cfg_wr_data[COORD_BITS-1:0];
                REG_FLAT_BAND:    cfg_band_reg <= cfg_wr_data[BAND_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    hep_front #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cand_x     (s_cand_x),
        .s_cand_y     (s_cand_y),
        .s_cand_z     (s_cand_z),
        .s_cand_index (s_cand_index),
        .s_run_last   (s_run_last),
        .cfg_start_x  (cfg_sx_reg),
        .cfg_start_y  (cfg_sy_reg),
        .cfg_start_z  (cfg_sz_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_tag        (q_tag),
        .q_index      (q_index),
        .q_cand_x     (q_cand_x),
        .q_cand_y     (q_cand_y),
        .q_cand_z     (q_cand_z),
        .q_dx         (q_dx),
        .q_dy         (q_dy),
        .q_dz         (q_dz)
    );

    assign q_push_data = {q_tag, q_index, q_cand_x, q_cand_y, q_cand_z, q_dx, q_dy, q_dz};

    hep_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (h_pop),
        .head_data  (h_data),
        .head_valid (h_valid)
    );

    assign {h_tag, h_index, h_cand_x, h_cand_y, h_cand_z, h_dx, h_dy, h_dz} = h_data;

    hep_back #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (h_valid),
        .head_tag      (h_tag),
        .head_index    (h_index),
        .head_cand_x   (h_cand_x),
        .head_cand_y   (h_cand_y),
        .head_cand_z   (h_cand_z),
        .head_dx       (h_dx),
        .head_dy       (h_dy),
        .head_dz       (h_dz),
        .head_pop      (h_pop),
        .cfg_start_x   (cfg_sx_reg),
        .cfg_start_y   (cfg_sy_reg),
        .cfg_start_z   (cfg_sz_reg),
        .cfg_end_x     (cfg_ex_reg),
        .cfg_end_y     (cfg_ey_reg),
        .cfg_end_z     (cfg_ez_reg),
        .cfg_band      (cfg_band_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pivot_index (m_pivot_index),
        .m_pivot_x     (m_pivot_x),
        .m_pivot_y     (m_pivot_y),
        .m_pivot_z     (m_pivot_z)
    );

endmodule
